### rtl/vrrq_pkg.sv
package vrrq_pkg;

   localparam int QUEUE_BYTES  = 1024;
   localparam int HEADER_BYTES = 4;
   localparam int MAX_RECORD   = 64;
   localparam int QUEUE_DEPTH  = 4;

   localparam int POS_W  = $clog2(QUEUE_BYTES);
   localparam int FREE_W = $clog2(QUEUE_BYTES + 1);
   localparam int RC_W   = $clog2(QUEUE_BYTES / HEADER_BYTES + 1);
   localparam int LEN_W  = 7;
   localparam int ADV_W  = $clog2(HEADER_BYTES + MAX_RECORD + 1);
   localparam int SUM_W  = POS_W + 8;
   localparam int ACC_W  = 8 * HEADER_BYTES;
   localparam int HCNT_W = $clog2(HEADER_BYTES + 1);

   localparam logic [2:0] OP_START  = 3'd0;
   localparam logic [2:0] OP_APPEND = 3'd1;
   localparam logic [2:0] OP_DEQ    = 3'd2;
   localparam logic [2:0] OP_PEEK   = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_NO_SPACE = 3'd1,
      ST_EMPTY    = 3'd2,
      ST_SEQ      = 3'd3,
      ST_TOO_LONG = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CMD_REPLY  = 2'd0,
      CMD_START  = 2'd1,
      CMD_APPEND = 2'd2,
      CMD_READ   = 2'd3
   } cmd_kind_type;

   typedef struct packed {
      logic [2:0]       operation;
      logic [LEN_W-1:0] length;
      logic [7:0]       data_byte;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [7:0]        out_byte;
      logic              byte_valid;
      logic              last;
      logic [FREE_W-1:0] free_bytes;
      logic              queue_empty;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type      kind;
      status_type        status;
      logic              dequeue;
      logic [LEN_W-1:0]  length;
      logic [7:0]        data_byte;
      logic [POS_W-1:0]  pos;
      logic [FREE_W-1:0] free;
   } cmd_type;

   typedef struct packed {
      logic             valid;
      logic [ADV_W-1:0] advance;
   } rep_type;

   function automatic logic [POS_W-1:0] ring_adv(input logic [POS_W-1:0] pos,
                                                 input logic [ADV_W-1:0] by);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(pos) + SUM_W'(by);
      if (sum >= SUM_W'(QUEUE_BYTES)) begin
         sum = sum - SUM_W'(QUEUE_BYTES);
      end
      return POS_W'(sum);
   endfunction

endpackage

### rtl/vrrq_front.sv
module vrrq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vrrq_pkg::req_type req_payload,
   input  logic              q_full,
   output logic              push,
   output vrrq_pkg::cmd_type push_cmd,
   input  vrrq_pkg::rep_type rep
);
   import vrrq_pkg::*;

   typedef enum logic [1:0] {
      F_RUN  = 2'b01,
      F_WAIT = 2'b10
   } front_state_type;

   front_state_type   state_ff, state_in;
   logic [POS_W-1:0]  head_ff, head_in;
   logic [POS_W-1:0]  tail_ff, tail_in;
   logic [FREE_W-1:0] free_ff, free_in;
   logic [LEN_W-1:0]  open_ff, open_in;
   logic [RC_W-1:0]   rc_ff, rc_in;
   logic              accept;
   logic [FREE_W:0]   free_sum;

   assign req_ready = (state_ff == F_RUN) && !q_full;
   assign accept    = req_valid && req_ready;
   assign push      = accept;
   assign free_sum  = {1'b0, free_ff} + (FREE_W + 1)'(rep.advance);

   always_comb begin
      state_in = state_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      free_in  = free_ff;
      open_in  = open_ff;
      rc_in    = rc_ff;

      push_cmd.kind      = CMD_REPLY;
      push_cmd.status    = ST_OK;
      push_cmd.dequeue   = 1'b0;
      push_cmd.length    = req_payload.length;
      push_cmd.data_byte = req_payload.data_byte;
      push_cmd.pos       = tail_ff;

      unique case (state_ff)
         F_RUN: begin
            if (accept) begin
               unique case (req_payload.operation) inside
                  OP_START: begin
                     if (open_ff != '0) begin
                        push_cmd.status = ST_SEQ;
                     end else if (req_payload.length > LEN_W'(MAX_RECORD)) begin
                        push_cmd.status = ST_TOO_LONG;
                     end else if (SUM_W'(free_ff) < SUM_W'(HEADER_BYTES)
                                  + SUM_W'(req_payload.length)) begin
                        push_cmd.status = ST_NO_SPACE;
                     end else begin
                        push_cmd.kind = CMD_START;
                        free_in = free_ff - FREE_W'(HEADER_BYTES)
                                  - FREE_W'(req_payload.length);
                        tail_in = ring_adv(tail_ff, ADV_W'(HEADER_BYTES));
                        open_in = req_payload.length;
                        if (req_payload.length == '0) begin
                           rc_in = rc_ff + 1'b1;
                        end
                     end
                  end
                  OP_APPEND: begin
                     if (open_ff == '0) begin
                        push_cmd.status = ST_SEQ;
                     end else begin
                        push_cmd.kind = CMD_APPEND;
                        tail_in = ring_adv(tail_ff, ADV_W'(1));
                        open_in = open_ff - 1'b1;
                        if (open_ff == LEN_W'(1)) begin
                           rc_in = rc_ff + 1'b1;
                        end
                     end
                  end
                  OP_DEQ, OP_PEEK: begin
                     if (rc_ff == '0) begin
                        push_cmd.status = ST_EMPTY;
                     end else begin
                        push_cmd.kind = CMD_READ;
                        push_cmd.pos  = head_ff;
                        if (req_payload.operation == OP_DEQ) begin
                           push_cmd.dequeue = 1'b1;
                           rc_in    = rc_ff - 1'b1;
                           state_in = F_WAIT;
                        end
                     end
                  end
                  OP_CLEAR: begin
                     head_in = '0;
                     tail_in = '0;
                     free_in = FREE_W'(QUEUE_BYTES);
                     open_in = '0;
                     rc_in   = '0;
                  end
                  default: begin
                     push_cmd.status = ST_SEQ;
                  end
               endcase
            end
         end
         F_WAIT: begin
            // header plus stored length of the dequeued record comes back from the read side
            if (rep.valid) begin
               head_in  = ring_adv(head_ff, rep.advance);
               free_in  = (free_sum > (FREE_W + 1)'(QUEUE_BYTES)) ?
                          FREE_W'(QUEUE_BYTES) : FREE_W'(free_sum);
               state_in = F_RUN;
            end
         end
         default: begin
            state_in = F_RUN;
         end
      endcase
      push_cmd.free = free_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_RUN;
         head_ff  <= '0;
         tail_ff  <= '0;
         free_ff  <= FREE_W'(QUEUE_BYTES);
         open_ff  <= '0;
         rc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         free_ff  <= free_in;
         open_ff  <= open_in;
         rc_ff    <= rc_in;
      end
   end

endmodule

### rtl/vrrq_cmd_queue.sv
module vrrq_cmd_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  vrrq_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output vrrq_pkg::cmd_type head_cmd
);
   import vrrq_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type           slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in;
   logic [PTR_W-1:0]  rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### rtl/vrrq_back.sv
module vrrq_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  vrrq_pkg::cmd_type q_head,
   output logic              pop,
   output vrrq_pkg::rep_type rep,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vrrq_pkg::rsp_type rsp_payload
);
   import vrrq_pkg::*;

   typedef enum logic [4:0] {
      B_IDLE  = 5'b00001,
      B_WRITE = 5'b00010,
      B_HDR   = 5'b00100,
      B_EMIT  = 5'b01000,
      B_REPLY = 5'b10000
   } back_state_type;

   logic [7:0]        ring_mem [QUEUE_BYTES];

   back_state_type    state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [HCNT_W-1:0] cnt_ff, cnt_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [LEN_W-1:0]  remain_ff, remain_in;
   logic [FREE_W-1:0] free_ff, free_in;
   logic [7:0]        rdata_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              mem_we, mem_re;
   logic [POS_W-1:0]  mem_addr;
   logic [7:0]        mem_wdata;
   logic              slot_free;
   logic [ACC_W-1:0]  hdr_word, hdr_full;
   logic [LEN_W-1:0]  stored, nbytes;
   logic [ADV_W-1:0]  advance;
   logic [FREE_W:0]   free_sum;

   assign slot_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // little-endian header: new bytes enter at the top
   assign hdr_word = ACC_W'(cmd_ff.length);
   assign hdr_full = (acc_ff >> 8) | (ACC_W'(rdata_ff) << (ACC_W - 8));
   assign stored   = (hdr_full > ACC_W'(MAX_RECORD)) ? LEN_W'(MAX_RECORD)
                                                     : LEN_W'(hdr_full);
   assign nbytes   = (cmd_ff.length < stored) ? cmd_ff.length : stored;
   assign advance  = ADV_W'(HEADER_BYTES) + ADV_W'(stored);
   assign free_sum = {1'b0, free_ff} + (FREE_W + 1)'(advance);

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      pos_in       = pos_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      remain_in    = remain_ff;
      free_in      = free_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = pos_ff;
      mem_wdata    = cmd_ff.data_byte;
      rep.valid    = 1'b0;
      rep.advance  = advance;

      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               pop     = 1'b1;
               cmd_in  = q_head;
               pos_in  = q_head.pos;
               free_in = q_head.free;
               cnt_in  = '0;
               acc_in  = '0;
               unique case (q_head.kind) inside
                  CMD_START, CMD_APPEND: state_in = B_WRITE;
                  CMD_READ:              state_in = B_HDR;
                  default:               state_in = B_REPLY;
               endcase
            end
         end
         B_WRITE: begin
            mem_we = 1'b1;
            if (cmd_ff.kind == CMD_START) begin
               mem_wdata = 8'(hdr_word >> {cnt_ff, 3'b000});
            end
            pos_in = ring_adv(pos_ff, ADV_W'(1));
            cnt_in = cnt_ff + 1'b1;
            if (cmd_ff.kind == CMD_APPEND || cnt_ff == HCNT_W'(HEADER_BYTES - 1)) begin
               state_in = B_REPLY;
            end
         end
         B_HDR: begin
            // one header byte read per cycle, its data is registered and lands in the next cycle
            if (cnt_ff < HCNT_W'(HEADER_BYTES)) begin
               mem_re = 1'b1;
               pos_in = ring_adv(pos_ff, ADV_W'(1));
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff != '0) begin
                  acc_in = hdr_full;
               end
            end else begin
               if (cmd_ff.dequeue) begin
                  rep.valid = 1'b1;
                  free_in   = (free_sum > (FREE_W + 1)'(QUEUE_BYTES)) ?
                              FREE_W'(QUEUE_BYTES) : FREE_W'(free_sum);
               end
               if (nbytes == '0) begin
                  state_in = B_REPLY;
               end else begin
                  mem_re    = 1'b1;
                  pos_in    = ring_adv(pos_ff, ADV_W'(1));
                  remain_in = nbytes;
                  state_in  = B_EMIT;
               end
            end
         end
         B_EMIT: begin
            if (slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = ST_OK;
               rsp_in.out_byte    = rdata_ff;
               rsp_in.byte_valid  = 1'b1;
               rsp_in.last        = (remain_ff == LEN_W'(1));
               rsp_in.free_bytes  = free_ff;
               rsp_in.queue_empty = (free_ff == FREE_W'(QUEUE_BYTES));
               remain_in          = remain_ff - 1'b1;
               if (remain_ff == LEN_W'(1)) begin
                  state_in = B_IDLE;
               end else begin
                  mem_re = 1'b1;
                  pos_in = ring_adv(pos_ff, ADV_W'(1));
               end
            end
         end
         B_REPLY: begin
            if (slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_in.status      = cmd_ff.status;
               rsp_in.out_byte    = '0;
               rsp_in.byte_valid  = 1'b0;
               rsp_in.last        = 1'b1;
               rsp_in.free_bytes  = free_ff;
               rsp_in.queue_empty = (free_ff == FREE_W'(QUEUE_BYTES));
               state_in           = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_addr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= ring_mem[mem_addr];
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      pos_ff    <= pos_in;
      acc_ff    <= acc_in;
      remain_ff <= remain_in;
      free_ff   <= free_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/variable_record_ring_queue.sv
// reads: header bytes are read back first, then one byte per cycle while rsp_ready allows
// throughput set by the back end, which handles one item at a time
// a dequeue holds off new input until its header has been read back
// reset: synchronous; pointers, counters and handshakes cleared, ring contents kept
module variable_record_ring_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vrrq_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vrrq_pkg::rsp_type rsp_payload
);
   import vrrq_pkg::*;

   // front to queue
   logic    push;
   cmd_type push_cmd;
   logic    q_full;

   // queue to back
   logic    pop;
   logic    q_empty;
   cmd_type q_head;

   // back to front: bytes (header plus record) that a dequeue has just removed
   rep_type rep;

   // front: checks each transfer against the bookkeeping and decides its status
   vrrq_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_full      (q_full),
      .push        (push),
      .push_cmd    (push_cmd),
      .rep         (rep)
   );

   // short command queue so the two halves stall independently
   vrrq_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .full     (q_full),
      .pop      (pop),
      .empty    (q_empty),
      .head_cmd (q_head)
   );

   // back: owns the ring memory, writes headers and bytes, reads records out
   vrrq_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_head      (q_head),
      .pop         (pop),
      .rep         (rep),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

### tb/vrrq_checker.sv
`timescale 1ns / 100ps

module vrrq_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  vrrq_pkg::req_type req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  vrrq_pkg::rsp_type rsp_payload,
   output int                fail_count,
   output int                pending_count
);
   import vrrq_pkg::*;

   // shadow copy of the ring and its bookkeeping
   logic [7:0]        ring_bytes [QUEUE_BYTES];
   logic [POS_W-1:0]  read_pos;
   logic [POS_W-1:0]  write_pos;
   logic [FREE_W-1:0] bytes_free;
   logic [LEN_W-1:0]  open_left;
   int                committed;

   rsp_type expected_rsp_q [$];
   int      errors = 0;
   int      rsp_index = 0;
   int      expected_count = 0;

   assign fail_count    = errors;
   assign pending_count = expected_count;

   function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] pos);
      return (pos == POS_W'(QUEUE_BYTES - 1)) ? '0 : pos + 1'b1;
   endfunction

   function automatic rsp_type make_rsp(input status_type st, input logic [7:0] b,
                                        input logic bv, input logic lst);
      rsp_type r;
      r.status      = st;
      r.out_byte    = b;
      r.byte_valid  = bv;
      r.last        = lst;
      r.free_bytes  = bytes_free;
      r.queue_empty = (bytes_free == FREE_W'(QUEUE_BYTES));
      return r;
   endfunction

   task automatic predict_queue_op(input req_type r);
      logic [31:0]      hdr;
      logic [POS_W-1:0] p;
      int               i;
      int               stored;
      int               n;
      int               f;
      case (r.operation) inside
         OP_START: begin
            if (open_left != '0) begin
               expected_rsp_q.push_back(make_rsp(ST_SEQ, 8'h00, 1'b0, 1'b1));
            end else if (int'(r.length) > MAX_RECORD) begin
               expected_rsp_q.push_back(make_rsp(ST_TOO_LONG, 8'h00, 1'b0, 1'b1));
            end else if (int'(bytes_free) < HEADER_BYTES + int'(r.length)) begin
               expected_rsp_q.push_back(make_rsp(ST_NO_SPACE, 8'h00, 1'b0, 1'b1));
            end else begin
               bytes_free = bytes_free - FREE_W'(HEADER_BYTES + int'(r.length));
               // little-endian length header
               for (i = 0; i < HEADER_BYTES; i++) begin
                  ring_bytes[write_pos] = 8'(32'(r.length) >> (8 * i));
                  write_pos = next_pos(write_pos);
               end
               open_left = r.length;
               if (r.length == '0) begin
                  committed++;
               end
               expected_rsp_q.push_back(make_rsp(ST_OK, 8'h00, 1'b0, 1'b1));
            end
         end
         OP_APPEND: begin
            if (open_left == '0) begin
               expected_rsp_q.push_back(make_rsp(ST_SEQ, 8'h00, 1'b0, 1'b1));
            end else begin
               ring_bytes[write_pos] = r.data_byte;
               write_pos = next_pos(write_pos);
               open_left = open_left - 1'b1;
               if (open_left == '0) begin
                  committed++;
               end
               expected_rsp_q.push_back(make_rsp(ST_OK, 8'h00, 1'b0, 1'b1));
            end
         end
         OP_DEQ, OP_PEEK: begin
            if (committed == 0) begin
               expected_rsp_q.push_back(make_rsp(ST_EMPTY, 8'h00, 1'b0, 1'b1));
            end else begin
               hdr = '0;
               p   = read_pos;
               for (i = 0; i < HEADER_BYTES; i++) begin
                  hdr = hdr | (32'(ring_bytes[p]) << (8 * i));
                  p   = next_pos(p);
               end
               stored = (hdr > 32'(MAX_RECORD)) ? MAX_RECORD : int'(hdr);
               n      = (int'(r.length) < stored) ? int'(r.length) : stored;
               // dequeue frees the whole record, whatever was asked for
               if (r.operation == OP_DEQ) begin
                  for (i = 0; i < HEADER_BYTES + stored; i++) begin
                     read_pos = next_pos(read_pos);
                  end
                  f = int'(bytes_free) + HEADER_BYTES + stored;
                  if (f > QUEUE_BYTES) begin
                     f = QUEUE_BYTES;
                  end
                  bytes_free = FREE_W'(f);
                  committed--;
               end
               if (n == 0) begin
                  expected_rsp_q.push_back(make_rsp(ST_OK, 8'h00, 1'b0, 1'b1));
               end else begin
                  for (i = 0; i < n; i++) begin
                     expected_rsp_q.push_back(make_rsp(ST_OK, ring_bytes[p], 1'b1,
                                                       i == n - 1));
                     p = next_pos(p);
                  end
               end
            end
         end
         OP_CLEAR: begin
            read_pos   = '0;
            write_pos  = '0;
            bytes_free = FREE_W'(QUEUE_BYTES);
            open_left  = '0;
            committed  = 0;
            expected_rsp_q.push_back(make_rsp(ST_OK, 8'h00, 1'b0, 1'b1));
         end
         default: begin
            expected_rsp_q.push_back(make_rsp(ST_SEQ, 8'h00, 1'b0, 1'b1));
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         read_pos   = '0;
         write_pos  = '0;
         bytes_free = FREE_W'(QUEUE_BYTES);
         open_left  = '0;
         committed  = 0;
         expected_rsp_q.delete();
         expected_count <= 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_queue_op(req_payload);
         end
         if (rsp_valid && rsp_ready) begin
            rsp_index++;
            if (expected_rsp_q.size() == 0) begin
               errors++;
               if (errors <= 10) begin
                  $display("response %0d arrived with nothing expected", rsp_index);
               end
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               if (rsp_payload.status !== exp_rsp.status ||
                   rsp_payload.out_byte !== exp_rsp.out_byte ||
                   rsp_payload.byte_valid !== exp_rsp.byte_valid ||
                   rsp_payload.last !== exp_rsp.last ||
                   rsp_payload.free_bytes !== exp_rsp.free_bytes ||
                   rsp_payload.queue_empty !== exp_rsp.queue_empty) begin
                  errors++;
                  if (errors <= 10) begin
                     $write("response %0d expected: status %0d byte %02h valid %0b",
                            rsp_index, exp_rsp.status, exp_rsp.out_byte,
                            exp_rsp.byte_valid);
                     $display(" last %0b free %0d empty %0b",
                              exp_rsp.last, exp_rsp.free_bytes, exp_rsp.queue_empty);
                     $write("response %0d got:      status %0d byte %02h valid %0b",
                            rsp_index, rsp_payload.status, rsp_payload.out_byte,
                            rsp_payload.byte_valid);
                     $display(" last %0b free %0d empty %0b",
                              rsp_payload.last, rsp_payload.free_bytes,
                              rsp_payload.queue_empty);
                  end
               end
            end
         end
         expected_count <= expected_rsp_q.size();
      end
   end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import vrrq_pkg::*;

   localparam int CLOCK_PERIOD  = 20;
   localparam int RESET_CYCLES  = 12;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_ITEMS  = 130;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 40;

   // opcodes the block does not define
   localparam logic [2:0] OP_UNUSED_LO = 3'd5;
   localparam logic [2:0] OP_UNUSED_HI = 3'd7;

   // long record sent while the receiver holds off, so the block backs up
   localparam int STALL_RECORD = 61;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   int fail_count;
   int pending_count;

   // shared between sender and receiver
   bit idle_on  = 1'b1;
   bit hold_rsp = 1'b0;

   int item_count  = 0;
   int read_count  = 0;
   int rsp_count   = 0;
   int cycle_count = 0;

   variable_record_ring_queue i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   vrrq_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // watchdog on total run length
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(255, 0));
   endfunction

   // one request transfer; valid stays high afterwards unless the next call idles
   // or the caller drains, so valid is never dropped and raised in the same step
   task automatic send_req(input logic [2:0] op, input int len, input logic [7:0] data);
      int      gap;
      req_type r;
      gap         = idle_on ? $urandom_range(9, 0) : 0;
      r.operation = op;
      r.length    = LEN_W'(len);
      r.data_byte = data;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      item_count++;
      if (op == OP_DEQ || op == OP_PEEK) begin
         read_count++;
      end
   endtask

   // start item plus its payload appends; fewer or more appends break the sequence
   task automatic send_record(input int len, input int appends);
      send_req(OP_START, len, rand_byte());
      repeat (appends) send_req(OP_APPEND, $urandom_range(127, 0), rand_byte());
   endtask

   // sender goes quiet until every predicted response has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // response side: random ready gaps, plus one long hold on request
   initial begin : rsp_side
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            gap = idle_on ? $urandom_range(9, 0) : 0;
            if (gap > 0) begin
               rsp_ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         rsp_count++;
      end
   end

   initial begin : stimulus
      int pick;
      int len;
      int appends;
      int random_end;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: error statuses on an empty ring
      send_req(OP_DEQ, MAX_RECORD, 8'h00);
      send_req(OP_PEEK, 0, 8'h00);
      send_req(OP_APPEND, 0, 8'hff);
      send_req(OP_START, MAX_RECORD + 1, 8'h00);
      send_req(OP_START, (1 << LEN_W) - 1, 8'hff);
      // empty record commits at once, reads give a lone zero-byte response
      send_req(OP_START, 0, 8'h00);
      send_req(OP_PEEK, 5, 8'h00);
      send_req(OP_DEQ, 0, 8'h00);
      // open record: second start refused, reads see an empty queue
      send_req(OP_START, 3, 8'h00);
      send_req(OP_START, 2, 8'h00);
      send_req(OP_PEEK, MAX_RECORD, 8'h00);
      send_req(OP_APPEND, 0, 8'h00);
      send_req(OP_APPEND, 0, 8'hff);
      send_req(OP_APPEND, 0, 8'ha5);
      // read larger than the record, truncated peek, truncated dequeue
      send_req(OP_PEEK, MAX_RECORD, 8'h00);
      send_req(OP_PEEK, 2, 8'h00);
      send_req(OP_DEQ, 1, 8'h00);
      send_req(OP_DEQ, 1, 8'h00);
      // clear drops a committed record and an open one
      send_req(OP_START, 1, 8'h00);
      send_req(OP_APPEND, 0, 8'h5a);
      send_req(OP_START, 2, 8'h00);
      send_req(OP_APPEND, 0, 8'h3c);
      send_req(OP_CLEAR, 0, 8'h00);
      send_req(OP_APPEND, 0, 8'h81);
      send_req(OP_UNUSED_LO, 0, 8'h00);
      send_req(OP_UNUSED_HI, (1 << LEN_W) - 1, 8'hff);
      send_req(OP_PEEK, 1, 8'h00);
      send_req(OP_CLEAR, 0, 8'h00);

      // back pressure: receiver stalls while a long record and its readback pile up
      hold_rsp = 1'b1;
      send_record(STALL_RECORD, STALL_RECORD);
      send_req(OP_PEEK, MAX_RECORD, rand_byte());
      wait_drained();
      send_req(OP_DEQ, MAX_RECORD + 6, rand_byte());

      // random mix: mostly well-formed records, some broken sequences and noise
      random_end = item_count + RANDOM_ITEMS;
      while (item_count < random_end) begin
         if ($urandom_range(11, 0) == 0) begin
            idle_on = !idle_on;
         end
         pick = $urandom_range(99, 0);
         if (pick < 45) begin
            len     = ($urandom_range(4, 0) != 0) ? $urandom_range(12, 0)
                                                  : $urandom_range(MAX_RECORD, 13);
            appends = len;
            // broken sequence: too few or too many appends
            if ($urandom_range(9, 0) == 0) begin
               appends = $urandom_range(len + 2, 0);
            end
            send_record(len, appends);
         end else if (pick < 72) begin
            send_req(OP_DEQ, $urandom_range(MAX_RECORD + 6, 0), rand_byte());
         end else if (pick < 86) begin
            send_req(OP_PEEK, $urandom_range(MAX_RECORD + 6, 0), rand_byte());
         end else if (pick < 90) begin
            send_req(OP_START, $urandom_range((1 << LEN_W) - 1, MAX_RECORD + 1),
                     rand_byte());
         end else if (pick < 94) begin
            send_req(OP_APPEND, $urandom_range(127, 0), rand_byte());
         end else if (pick < 97) begin
            send_req(3'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO)),
                     $urandom_range(127, 0), rand_byte());
         end else begin
            send_req(OP_CLEAR, $urandom_range(127, 0), rand_byte());
         end
      end

      // let everything come back, then keep watching for stray responses
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d requests (%0d reads) and %0d response transfers:",
               item_count, read_count, rsp_count);
      $display("statuses, truncated reads, clears, broken sequences and a long output stall");
      if (fail_count == 0 && pending_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

### files.f
rtl/vrrq_pkg.sv
rtl/vrrq_front.sv
rtl/vrrq_cmd_queue.sv
rtl/vrrq_back.sv
rtl/variable_record_ring_queue.sv
tb/vrrq_checker.sv
tb/tb_top.sv
